[hdl/assert_macros.svh]
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_CLK(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`define ASSERT_CLK_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) (prop)) else $error(msg);

`else

`define ASSERT_CLK(name, prop, msg)

`define ASSERT_CLK_ALWAYS(name, prop, msg)

`endif

`endif

[hdl/cwa_pkg.sv]
// Types and constants for the congestion window block.
`default_nettype none

package cwa_pkg;

   localparam logic [1:0] OP_INIT    = 2'd0;
   localparam logic [1:0] OP_ACK     = 2'd1;
   localparam logic [1:0] OP_TIMEOUT = 2'd2;

   localparam logic CSR_MSS = 1'b0;
   localparam logic CSR_IW  = 1'b1;

   localparam logic [15:0] MSS_RESET = 16'd1460;
   localparam logic [31:0] IW_RESET  = 32'd4380;
   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] acked_bytes;
      logic [31:0] flight_bytes;
   } req_type;

   typedef struct packed {
      logic [31:0] window;
      logic [31:0] threshold;
      logic        in_loss;
      logic        grew_in_slow_start;
   } rsp_type;

endpackage

`default_nettype wire

[hdl/tcp_congestion_window_aimd.sv]
// Congestion window with slow start, congestion avoidance and timeout handling.
//
//   channel  | direction | handshake             | word
//   req_     | in        | req_valid / req_ready | req_type
//   rsp_     | out       | rsp_valid / rsp_ready | rsp_type
//   csr_     | in        | csr_write_en          | csr_index, csr_wdata
//
// Init, timeout, slow-start ack: go straight to ST_EMIT, which loads the output register once it is free.
// Congestion-avoidance ack: a 2-bit-per-cycle shift-add multiply followed by a
// 2-bit-per-cycle restoring divide, then ST_ADD and ST_EMIT.
// One item at a time; req_ready is high while the sequencer is idle, even
// while a finished word waits in the output register.
// Synchronous reset loads the reset window, threshold and register values.
`default_nettype none
`include "assert_macros.svh"

module tcp_congestion_window_aimd
   import cwa_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data,
   input  wire logic    csr_write_en,
   input  wire logic    csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   localparam logic [4:0] MUL_LAST = 5'd7;
   localparam logic [4:0] DIV_LAST = 5'd23;

   logic [2:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [15:0] mss_ff, mss_in;
   logic [31:0] iw_ff, iw_in;
   logic [31:0] cwnd_ff, cwnd_in;
   logic [31:0] ssth_ff, ssth_in;
   logic        loss_ff, loss_in;
   logic        grew_ff, grew_in;
   logic [31:0] acked_ff, acked_in;
   logic [15:0] msh_ff, msh_in;
   logic [47:0] acc_ff, acc_in;
   logic [31:0] rem_ff, rem_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic [31:0] divisor;
   logic [33:0] part;
   logic [32:0] step_a, step_b;
   logic [31:0] ss_inc;
   logic [32:0] ss_sum;
   logic [31:0] half;
   logic [31:0] two_mss;
   logic [31:0] ca_inc;
   logic [32:0] ca_sum;

   function automatic logic [32:0] div_step(input logic [31:0] rem, input logic din,
                                            input logic [31:0] dvs);
      logic [33:0] diff;
      diff = {1'b0, rem, din} - {2'b00, dvs};
      if (!diff[33]) begin
         div_step = {1'b1, diff[31:0]};
      end else begin
         div_step = {1'b0, rem[30:0], din};
      end
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      divisor = (cwnd_ff == 32'd0) ? 32'd1 : cwnd_ff;
      part    = ({2'b00, acked_ff} & {34{msh_ff[14]}})
              + ({1'b0, acked_ff, 1'b0} & {34{msh_ff[15]}});
      step_a  = div_step(rem_ff, acc_ff[47], divisor);
      step_b  = div_step(step_a[31:0], acc_ff[46], divisor);
      ss_inc  = (req_data.acked_bytes < {16'd0, mss_ff}) ? req_data.acked_bytes
                                                          : {16'd0, mss_ff};
      ss_sum  = {1'b0, cwnd_ff} + {1'b0, ss_inc};
      half    = {1'b0, req_data.flight_bytes[31:1]};
      two_mss = {15'd0, mss_ff, 1'b0};
      ca_inc  = (acc_ff == 48'd0) ? 32'd1 : acc_ff[31:0];
      ca_sum  = {1'b0, cwnd_ff} + {1'b0, ca_inc};
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mss_in       = mss_ff;
      iw_in        = iw_ff;
      cwnd_in      = cwnd_ff;
      ssth_in      = ssth_ff;
      loss_in      = loss_ff;
      grew_in      = grew_ff;
      acked_in     = acked_ff;
      msh_in       = msh_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_write_en) begin
         case (csr_index)
            CSR_MSS: mss_in = csr_wdata[15:0];
            CSR_IW:  iw_in  = csr_wdata;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               grew_in  = 1'b0;
               state_in = ST_EMIT;
               case (req_data.operation)
                  OP_INIT: begin
                     cwnd_in = iw_ff;
                     ssth_in = ALL_ONES;
                     loss_in = 1'b0;
                  end
                  OP_ACK: begin
                     loss_in = 1'b0;
                     if (cwnd_ff < ssth_ff) begin
                        grew_in = 1'b1;
                        cwnd_in = ss_sum[32] ? ALL_ONES : ss_sum[31:0];
                     end else begin
                        acked_in = req_data.acked_bytes;
                        msh_in   = mss_ff;
                        acc_in   = 48'd0;
                        cnt_in   = 5'd0;
                        state_in = ST_MUL;
                     end
                  end
                  OP_TIMEOUT: begin
                     ssth_in = (half > two_mss) ? half : two_mss;
                     cwnd_in = {16'd0, mss_ff};
                     loss_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            acc_in = {acc_ff[45:0], 2'b00} + {14'd0, part};
            msh_in = {msh_ff[13:0], 2'b00};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = 5'd0;
               rem_in   = 32'd0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            acc_in = {acc_ff[45:0], step_a[32], step_b[32]};
            rem_in = step_b[31:0];
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = 5'd0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if ((acc_ff[47:32] != 16'd0) || ca_sum[32]) begin
               cwnd_in = ALL_ONES;
            end else begin
               cwnd_in = ca_sum[31:0];
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.window             = cwnd_ff;
               rsp_data_in.threshold          = ssth_ff;
               rsp_data_in.in_loss            = loss_ff;
               rsp_data_in.grew_in_slow_start = grew_ff;
               state_in                       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 5'd0;
         mss_ff       <= MSS_RESET;
         iw_ff        <= IW_RESET;
         cwnd_ff      <= IW_RESET;
         ssth_ff      <= ALL_ONES;
         loss_ff      <= 1'b0;
         grew_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mss_ff       <= mss_in;
         iw_ff        <= iw_in;
         cwnd_ff      <= cwnd_in;
         ssth_ff      <= ssth_in;
         loss_ff      <= loss_in;
         grew_ff      <= grew_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acked_ff    <= acked_in;
      msh_ff      <= msh_in;
      acc_ff      <= acc_in;
      rem_ff      <= rem_in;
      rsp_data_ff <= rsp_data_in;
   end

   `ASSERT_CLK(a_accept_leaves_idle, (req_valid && req_ready) |=> (state_ff != ST_IDLE), "accepted word did not start work")
   `ASSERT_CLK(a_mul_count, (state_ff == ST_MUL) |-> (cnt_ff <= MUL_LAST), "multiply count out of range")
   `ASSERT_CLK(a_add_to_emit, (state_ff == ST_ADD) |=> (state_ff == ST_EMIT), "add step did not emit")
   `ASSERT_CLK_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff), "reset did not clear sequencer")

endmodule

`default_nettype wire
